@@ hdl/stuj_pkg.sv @@
// ----------------------------------------------------------------------------
// stuj_pkg
// Shared sizes, codes and the journal entry layout for the slot table core.
// ----------------------------------------------------------------------------
package stuj_pkg;

  // Table and journal geometry
  localparam int SLOTS         = 16;
  localparam int JOURNAL_DEPTH = 64;
  localparam int OWNER_BITS    = 16;

  // Fixed field widths of the ports
  localparam int KIND_W   = 2;
  localparam int SLOT_FW  = 5;
  localparam int OWNER_W  = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  // Derived widths
  localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int JA_W   = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
  localparam int JC_W   = $clog2(JOURNAL_DEPTH + 1);
  localparam int JE_W   = SIDX_W + 1 + OWNER_BITS;

  typedef enum logic [KIND_W-1:0] {
    KIND_ASSIGN = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_DUMP   = 2'd2,
    KIND_UNDO   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_JEMPTY = 2'd2,
    ST_JFULL  = 2'd3
  } status_e;

  // One journal record: slot index and its previous content
  typedef struct packed {
    logic [SIDX_W-1:0]     idx;
    logic                  valid;
    logic [OWNER_BITS-1:0] owner;
  } jrnl_entry_t;

endpackage

@@ hdl/stuj_ram.sv @@
// ----------------------------------------------------------------------------
// stuj_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module stuj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while re_i is low
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/slot_table_with_undo_journal_core.sv @@
// ----------------------------------------------------------------------------
// slot_table_with_undo_journal_core
// Slot table with owner numbers and an undo journal kept as a stack.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+------------------
//  in      | kind_i, slot_i, owner_i                    | in  | in_valid/ready
//  out     | owner_out_o, none_occupied_o, status_o,    | out | out_valid/ready
//          | last_o                                     |     |
//  cfg     | cfg_wdata_i (slots_in_use)                 | in  | cfg_we_i, no wait
//
//  Assign, free and undo: the accept cycle launches the RAM reads, and the
//  exec state then writes back and loads the result register.
//  A dump reads the occupied active slots in turn, one slot per cycle while
//  the output is not stalled, as set by the single read port of the owner RAM.
//  Reset clears the slot valid flops and the journal count at once; there is
//  no clearing pass. Journal RAM contents are not reset.
//  A stalled output register holds the sequencer in place; the next
//  transaction is taken as soon as the current one has loaded its last result.
// ----------------------------------------------------------------------------
module slot_table_with_undo_journal_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [stuj_pkg::CFG_W-1:0]      cfg_wdata_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [stuj_pkg::KIND_W-1:0]     kind_i,
  input  logic [stuj_pkg::SLOT_FW-1:0]    slot_i,
  input  logic [stuj_pkg::OWNER_W-1:0]    owner_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [stuj_pkg::OWNER_W-1:0]    owner_out_o,
  output logic                            none_occupied_o,
  output logic [stuj_pkg::STATUS_W-1:0]   status_o,
  output logic                            last_o
);

  import stuj_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_e;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [CFG_W-1:0]       slots_in_use_q, slots_in_use_d;
  logic [SLOTS-1:0]       slot_valid_q, slot_valid_d;   // per-slot occupied flag
  logic [JC_W-1:0]        jcount_q, jcount_d;           // journal entries held
  kind_e                  kind_q, kind_d;
  logic [SLOT_FW-1:0]     slot_q, slot_d;
  logic [OWNER_BITS-1:0]  owner_q, owner_d;
  logic [SLOTS-1:0]       mask_q, mask_d;               // dump: slots not yet read
  logic                   pend_q, pend_d;               // dump: read data waiting

  // result register
  logic                   out_valid_q, out_valid_d;
  logic [OWNER_W-1:0]     owner_out_q, owner_out_d;
  logic                   none_q, none_d;
  status_e                status_q, status_d;
  logic                   last_q, last_d;

  // --------------------------------------------------------------------------
  // RAM ports
  // --------------------------------------------------------------------------
  logic                   tbl_we, tbl_re;
  logic [SIDX_W-1:0]      tbl_waddr, tbl_raddr;
  logic [OWNER_BITS-1:0]  tbl_wdata, tbl_rdata;

  logic                   jr_we, jr_re;
  logic [JA_W-1:0]        jr_waddr, jr_raddr;
  jrnl_entry_t            jr_wdata, jr_rdata;
  logic [JE_W-1:0]        jr_rdata_raw;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  logic [SLOT_FW-1:0]     active;        // min(slots_in_use, SLOTS)
  logic [SLOTS-1:0]       active_mask;
  logic [SIDX_W-1:0]      slot_idx;      // zero-based slot of the held request
  logic [SIDX_W-1:0]      next_idx;      // lowest slot left to dump
  logic                   can_load;

  function automatic logic [SIDX_W-1:0] lowest_set(input logic [SLOTS-1:0] m);
    logic [SIDX_W-1:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = SIDX_W'(i);
      end
    end
    return r;
  endfunction

  assign active = (slots_in_use_q > SLOT_FW'(SLOTS)) ? SLOT_FW'(SLOTS)
                                                     : SLOT_FW'(slots_in_use_q);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      active_mask[i] = (SLOT_FW'(i) < active);
    end
  end

  assign slot_idx     = SIDX_W'(slot_q - SLOT_FW'(1));
  assign next_idx     = lowest_set(mask_q);
  assign can_load     = !out_valid_q || out_ready_i;
  assign jr_rdata     = jrnl_entry_t'(jr_rdata_raw);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    slots_in_use_d = cfg_we_i ? cfg_wdata_i : slots_in_use_q;
    slot_valid_d   = slot_valid_q;
    jcount_d       = jcount_q;
    kind_d         = kind_q;
    slot_d         = slot_q;
    owner_d        = owner_q;
    mask_d         = mask_q;
    pend_d         = pend_q;

    out_valid_d    = out_valid_q && !out_ready_i;
    owner_out_d    = owner_out_q;
    none_d         = none_q;
    status_d       = status_q;
    last_d         = last_q;

    tbl_we    = 1'b0;
    tbl_waddr = slot_idx;
    tbl_wdata = '0;
    tbl_re    = 1'b0;
    tbl_raddr = SIDX_W'(slot_i - SLOT_FW'(1));
    jr_we     = 1'b0;
    jr_waddr  = jcount_q[JA_W-1:0];
    jr_wdata  = '0;
    jr_re     = 1'b0;
    jr_raddr  = JA_W'(jcount_q - JC_W'(1));

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_e'(kind_i);
          slot_d  = slot_i;
          owner_d = owner_i[OWNER_BITS-1:0];
          if (kind_e'(kind_i) == KIND_DUMP) begin
            mask_d  = slot_valid_q & active_mask;
            pend_d  = 1'b0;
            state_d = S_DUMP;
          end else begin
            // fetch the slot's old owner and the newest journal record
            tbl_re  = 1'b1;
            jr_re   = 1'b1;
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          owner_out_d = '0;
          none_d      = 1'b0;
          last_d      = 1'b1;
          status_d    = ST_OK;
          state_d     = S_IDLE;
          if (kind_q == KIND_UNDO) begin
            if (jcount_q == '0) begin
              status_d = ST_JEMPTY;
            end else begin
              // restore the popped slot, active or not
              tbl_we                     = 1'b1;
              tbl_waddr                  = jr_rdata.idx;
              tbl_wdata                  = jr_rdata.owner;
              slot_valid_d[jr_rdata.idx] = jr_rdata.valid;
              jcount_d                   = jcount_q - JC_W'(1);
            end
          end else if (slot_q == '0 || slot_q > active) begin
            status_d = ST_RANGE;
          end else if (jcount_q == JC_W'(JOURNAL_DEPTH)) begin
            status_d = ST_JFULL;
          end else begin
            jr_we          = 1'b1;
            jr_wdata.idx   = slot_idx;
            jr_wdata.valid = slot_valid_q[slot_idx];
            jr_wdata.owner = tbl_rdata;
            jcount_d       = jcount_q + JC_W'(1);
            tbl_we         = 1'b1;
            tbl_wdata      = (kind_q == KIND_ASSIGN) ? owner_q : '0;
            slot_valid_d[slot_idx] = (kind_q == KIND_ASSIGN);
          end
        end
      end

      S_DUMP: begin
        if (pend_q) begin
          // owner of the previously read slot sits on the RAM output
          if (can_load) begin
            out_valid_d = 1'b1;
            owner_out_d = OWNER_W'(tbl_rdata);
            none_d      = 1'b0;
            status_d    = ST_OK;
            last_d      = (mask_q == '0);
            if (mask_q != '0) begin
              tbl_re           = 1'b1;
              tbl_raddr        = next_idx;
              mask_d[next_idx] = 1'b0;
            end else begin
              pend_d  = 1'b0;
              state_d = S_IDLE;
            end
          end
        end else if (mask_q == '0) begin
          // nothing occupied among the active slots
          if (can_load) begin
            out_valid_d = 1'b1;
            owner_out_d = '0;
            none_d      = 1'b1;
            status_d    = ST_OK;
            last_d      = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          tbl_re           = 1'b1;
          tbl_raddr        = next_idx;
          mask_d[next_idx] = 1'b0;
          pend_d           = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      slots_in_use_q <= CFG_W'(SLOTS);
      slot_valid_q   <= '0;
      jcount_q       <= '0;
      kind_q         <= KIND_ASSIGN;
      slot_q         <= '0;
      owner_q        <= '0;
      mask_q         <= '0;
      pend_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      owner_out_q    <= '0;
      none_q         <= 1'b0;
      status_q       <= ST_OK;
      last_q         <= 1'b0;
    end else begin
      state_q        <= state_d;
      slots_in_use_q <= slots_in_use_d;
      slot_valid_q   <= slot_valid_d;
      jcount_q       <= jcount_d;
      kind_q         <= kind_d;
      slot_q         <= slot_d;
      owner_q        <= owner_d;
      mask_q         <= mask_d;
      pend_q         <= pend_d;
      out_valid_q    <= out_valid_d;
      owner_out_q    <= owner_out_d;
      none_q         <= none_d;
      status_q       <= status_d;
      last_q         <= last_d;
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  stuj_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (SLOTS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  stuj_ram #(
    .WIDTH (JE_W),
    .DEPTH (JOURNAL_DEPTH)
  ) u_journal_ram (
    .clk_i   (clk_i),
    .we_i    (jr_we),
    .waddr_i (jr_waddr),
    .wdata_i (JE_W'(jr_wdata)),
    .re_i    (jr_re),
    .raddr_i (jr_raddr),
    .rdata_o (jr_rdata_raw)
  );

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign owner_out_o     = owner_out_q;
  assign none_occupied_o = none_q;
  assign status_o        = status_q;
  assign last_o          = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // journal count moves by at most one per transaction
  a_jcount_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (jcount_q != $past(jcount_q)) |->
      (jcount_q == $past(jcount_q) + JC_W'(1) || jcount_q == $past(jcount_q) - JC_W'(1)))
    else $error("journal count jumped");

  // occupancy flags change only on a write-back
  a_valid_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_EXEC) |=> $stable(slot_valid_q))
    else $error("slot flags changed outside write-back");

  // owner RAM is never read and written in the same cycle
  a_tbl_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tbl_we && tbl_re))
    else $error("owner RAM read and write overlap");

  // an empty dump result is always the only, final one
  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_occupied_o) |-> (last_o && status_o == ST_OK && owner_out_o == '0))
    else $error("malformed empty dump result");

endmodule

@@ bench/tb_slot_table_with_undo_journal_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_table_with_undo_journal_core
// Self-checking bench for the slot table core. A directed table covers reset
// state, range errors, undo on an empty journal and active-count changes. It
// is followed by a journal fill to overflow and random traffic under several
// idle/stall mixes. Results are checked against typed rows or a local table model.
// ----------------------------------------------------------------------------
module tb_slot_table_with_undo_journal_core;
  import stuj_pkg::*;

  // No-progress cycles before giving up. A 16-result dump under 84% receiver
  // stall needs far fewer than this.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last expected result, to catch stray output
  localparam int TAIL_CYCLES    = 20;
  localparam int RAND_PER_PHASE = 21;

  // One result transaction
  typedef struct packed {
    logic [OWNER_W-1:0] owner_out;
    logic               none_occ;
    status_e            status;
    logic               last;
  } result_t;

  // Directed row: either a request or an active-count write (value in s)
  typedef struct packed {
    logic               cfg_row;
    kind_e              k;
    logic [SLOT_FW-1:0] s;
    logic [OWNER_W-1:0] o;
    logic               typed;   // res below is the expected single result
    result_t            res;
  } stim_row_t;

  localparam result_t RES_OK     = '{16'h0000, 1'b0, ST_OK,     1'b1};
  localparam result_t RES_NONE   = '{16'h0000, 1'b1, ST_OK,     1'b1};
  localparam result_t RES_RANGE  = '{16'h0000, 1'b0, ST_RANGE,  1'b1};
  localparam result_t RES_JEMPTY = '{16'h0000, 1'b0, ST_JEMPTY, 1'b1};

  // Rows with typed = 0 are checked against the model only.
  localparam stim_row_t DIR_ROWS [26] = '{
    '{1'b0, KIND_DUMP,   5'd0,  16'h0000, 1'b1, RES_NONE},    // empty table
    '{1'b0, KIND_UNDO,   5'd0,  16'h0000, 1'b1, RES_JEMPTY},  // nothing to undo
    '{1'b0, KIND_ASSIGN, 5'd0,  16'hFFFF, 1'b1, RES_RANGE},   // slot zero
    '{1'b0, KIND_ASSIGN, 5'd17, 16'hFFFF, 1'b1, RES_RANGE},   // just above table
    '{1'b0, KIND_FREE,   5'd31, 16'h0000, 1'b1, RES_RANGE},   // field maximum
    '{1'b0, KIND_FREE,   5'd0,  16'h0000, 1'b1, RES_RANGE},
    '{1'b0, KIND_ASSIGN, 5'd1,  16'h0000, 1'b1, RES_OK},      // owner zero
    '{1'b0, KIND_ASSIGN, 5'd16, 16'hFFFF, 1'b1, RES_OK},      // top slot, max owner
    '{1'b0, KIND_ASSIGN, 5'd8,  16'hA5A5, 1'b1, RES_OK},
    '{1'b0, KIND_DUMP,   5'd0,  16'h0000, 1'b0, RES_OK},
    '{1'b0, KIND_FREE,   5'd8,  16'h0000, 1'b1, RES_OK},
    '{1'b0, KIND_FREE,   5'd8,  16'h0000, 1'b1, RES_OK},      // free an empty slot
    '{1'b0, KIND_ASSIGN, 5'd1,  16'h1234, 1'b1, RES_OK},      // overwrite
    '{1'b0, KIND_UNDO,   5'd0,  16'h0000, 1'b1, RES_OK},
    '{1'b0, KIND_DUMP,   5'd0,  16'h0000, 1'b0, RES_OK},
    '{1'b1, KIND_ASSIGN, 5'd1,  16'h0000, 1'b0, RES_OK},      // one active slot
    '{1'b0, KIND_DUMP,   5'd0,  16'h0000, 1'b0, RES_OK},
    '{1'b0, KIND_ASSIGN, 5'd2,  16'h00FF, 1'b1, RES_RANGE},
    '{1'b0, KIND_FREE,   5'd1,  16'h0000, 1'b1, RES_OK},
    '{1'b0, KIND_DUMP,   5'd0,  16'h0000, 1'b0, RES_OK},
    '{1'b1, KIND_ASSIGN, 5'd0,  16'h0000, 1'b0, RES_OK},      // no active slot
    '{1'b0, KIND_ASSIGN, 5'd1,  16'h5555, 1'b1, RES_RANGE},
    '{1'b0, KIND_DUMP,   5'd0,  16'h0000, 1'b1, RES_NONE},
    '{1'b0, KIND_UNDO,   5'd0,  16'h0000, 1'b1, RES_OK},      // restores inactive slot
    '{1'b1, KIND_ASSIGN, 5'd31, 16'h0000, 1'b0, RES_OK},      // above SLOTS, acts as 16
    '{1'b0, KIND_DUMP,   5'd0,  16'h0000, 1'b0, RES_OK}
  };

  // Random phases: active count, sender idle %, receiver stall %
  localparam int PH_CFG [4]       = '{16, 7, 31, 12};
  localparam int PH_IN_IDLE [4]   = '{0, 84, 0, 27};
  localparam int PH_OUT_STALL [4] = '{0, 0, 84, 27};

  // DUT connections, all inputs known from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we        = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata     = 5'd16;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind          = KIND_ASSIGN;
  logic [SLOT_FW-1:0]  slot          = '0;
  logic [OWNER_W-1:0]  owner         = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic [OWNER_W-1:0]  owner_out;
  logic                none_occupied;
  logic [STATUS_W-1:0] status;
  logic                last;

  // Table model state
  logic [CFG_W-1:0]      slots_cfg = 5'd16;
  logic                  tbl_valid [SLOTS];
  logic [OWNER_BITS-1:0] tbl_owner [SLOTS];
  logic [SIDX_W-1:0]     undo_slot [JOURNAL_DEPTH];
  logic                  undo_valid [JOURNAL_DEPTH];
  logic [OWNER_BITS-1:0] undo_owner [JOURNAL_DEPTH];
  int unsigned           undo_depth = 0;

  result_t step_res [$];          // results of the request just modeled
  result_t expected_results [$];  // outstanding, oldest first
  result_t want_res;

  int mismatches    = 0;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int stuck_cycles  = 0;

  slot_table_with_undo_journal_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .slot_i         (slot),
    .owner_i        (owner),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .owner_out_o    (owner_out),
    .none_occupied_o(none_occupied),
    .status_o       (status),
    .last_o         (last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_owner[i] = '0;
    end
  end

  function automatic int unsigned active_slots();
    return (slots_cfg > SLOTS) ? SLOTS : slots_cfg;
  endfunction

  function automatic result_t mk_res(logic [OWNER_W-1:0] o, logic n, status_e st, logic l);
    mk_res = '{o, n, st, l};
  endfunction

  // Apply one request to the table model; fills step_res.
  function automatic void predict_results(kind_e k, logic [SLOT_FW-1:0] s,
                                          logic [OWNER_W-1:0] o);
    int unsigned act;
    int unsigned idx;
    act = active_slots();
    step_res.delete();
    case (k)
      KIND_DUMP: begin
        for (int i = 0; i < act; i++)
          if (tbl_valid[i]) step_res.push_back(mk_res(tbl_owner[i], 1'b0, ST_OK, 1'b0));
        if (step_res.size() == 0) step_res.push_back(mk_res('0, 1'b1, ST_OK, 1'b1));
        else step_res[step_res.size()-1].last = 1'b1;
      end
      KIND_UNDO: begin
        if (undo_depth == 0) begin
          step_res.push_back(mk_res('0, 1'b0, ST_JEMPTY, 1'b1));
        end else begin
          // restores even when the slot is no longer active
          undo_depth--;
          tbl_valid[undo_slot[undo_depth]] = undo_valid[undo_depth];
          tbl_owner[undo_slot[undo_depth]] = undo_owner[undo_depth];
          step_res.push_back(mk_res('0, 1'b0, ST_OK, 1'b1));
        end
      end
      default: begin
        // assign / free: range check first, then journal space
        if (s == 0 || s > act) begin
          step_res.push_back(mk_res('0, 1'b0, ST_RANGE, 1'b1));
        end else if (undo_depth >= JOURNAL_DEPTH) begin
          step_res.push_back(mk_res('0, 1'b0, ST_JFULL, 1'b1));
        end else begin
          idx = s - 1;
          undo_slot[undo_depth]  = idx[SIDX_W-1:0];
          undo_valid[undo_depth] = tbl_valid[idx];
          undo_owner[undo_depth] = tbl_owner[idx];
          undo_depth++;
          tbl_valid[idx] = (k == KIND_ASSIGN);
          tbl_owner[idx] = (k == KIND_ASSIGN) ? o[OWNER_BITS-1:0] : '0;
          step_res.push_back(mk_res('0, 1'b0, ST_OK, 1'b1));
        end
      end
    endcase
  endfunction

  // Present one request, hold it until taken, then queue its results.
  // Valid only drops when the sender decides to idle or the bench drains.
  task automatic send_req(kind_e k, logic [SLOT_FW-1:0] s, logic [OWNER_W-1:0] o,
                          logic typed, result_t typed_res);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= k;
    slot     <= s;
    owner    <= o;
    do @(posedge clk_i); while (!in_ready);
    predict_results(k, s, o);
    if (typed) expected_results.push_back(typed_res);
    else foreach (step_res[i]) expected_results.push_back(step_res[i]);
  endtask

  task automatic send_random();
    kind_e                k;
    logic [SLOT_FW-1:0]   s;
    logic [OWNER_W-1:0]   o;
    int unsigned          pick;
    int unsigned          act;
    act  = active_slots();
    pick = $urandom_range(99);
    k = (pick < 30) ? KIND_ASSIGN : (pick < 50) ? KIND_FREE :
        (pick < 65) ? KIND_DUMP : KIND_UNDO;
    // mostly in-range slots, some noise across the whole field
    if ($urandom_range(9) == 0 || act == 0) s = SLOT_FW'($urandom_range(31));
    else s = SLOT_FW'($urandom_range(act, 1));
    pick = $urandom_range(9);
    o = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : OWNER_W'($urandom);
    send_req(k, s, o, 1'b0, RES_OK);
  endtask

  // Hold off new requests until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Active count is only changed with the core idle.
  task automatic write_slots_in_use(logic [CFG_W-1:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    slots_cfg = v;
  endtask

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Receiver: per-cycle random stall at the current phase rate
  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= out_stall_pct);

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual owner_out=%h none=%b st=%0d last=%b",
                 $time, owner_out, none_occupied, status, last);
        mismatches++;
      end else begin
        want_res = expected_results.pop_front();
        check_field("owner_out", want_res.owner_out, owner_out);
        check_field("none_occupied", want_res.none_occ, none_occupied);
        check_field("status", want_res.status, status);
        check_field("last", want_res.last, last);
      end
    end
  end

  // Watchdog: no transaction on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expected_results.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].cfg_row) write_slots_in_use(DIR_ROWS[i].s);
      else send_req(DIR_ROWS[i].k, DIR_ROWS[i].s, DIR_ROWS[i].o,
                    DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    // Random phases; each starts drained, with a new active count
    for (int p = 0; p < 4; p++) begin
      write_slots_in_use(CFG_W'(PH_CFG[p]));
      in_idle_pct   = PH_IN_IDLE[p];
      out_stall_pct = PH_OUT_STALL[p];
      if (p == 0) begin
        // fill the journal with random in-range changes, then overflow it twice
        while (undo_depth < JOURNAL_DEPTH)
          send_req(($urandom_range(3) == 0) ? KIND_FREE : KIND_ASSIGN,
                   SLOT_FW'($urandom_range(SLOTS, 1)), OWNER_W'($urandom), 1'b0, RES_OK);
        send_req(KIND_ASSIGN, SLOT_FW'($urandom_range(SLOTS, 1)), OWNER_W'($urandom),
                 1'b0, RES_OK);
        send_req(KIND_FREE, SLOT_FW'($urandom_range(SLOTS, 1)), '0, 1'b0, RES_OK);
      end
      repeat (RAND_PER_PHASE) send_random();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
